[rtl/integer_to_ascii_digits_unit_macros.svh]
`ifndef INTEGER_TO_ASCII_DIGITS_UNIT_MACROS_SVH
`define INTEGER_TO_ASCII_DIGITS_UNIT_MACROS_SVH

// same-cycle implication, checked on clk_i, off during reset
`define I2A_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i, off during reset
`define I2A_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/i2a_pkg.sv]
`timescale 1ns / 1ps

package i2a_pkg;

  // mode codes
  localparam logic [1:0] FUNC_SDEC = 2'd0;
  localparam logic [1:0] FUNC_UDEC = 2'd1;
  localparam logic [1:0] FUNC_HEX  = 2'd2;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ALPHA = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] DEC_BASE = 8'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_SIGN,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic scan;
    logic dec;
    logic sign_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic neg;
    logic idx_zero;
  } sts_t;

endpackage

[rtl/i2a_ctrl.sv]
`timescale 1ns / 1ps

module i2a_ctrl #(
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic [1:0]   func_i,
  input  logic         out_ready_i,
  input  i2a_pkg::sts_t sts_i,
  output i2a_pkg::cmd_t cmd_o,
  output logic         in_ready_o,
  output logic         out_valid_o,
  output logic         last_o
);
  import i2a_pkg::*;

  localparam int NITER = (DATA_WIDTH + 3) / 4;
  localparam int ITW   = (NITER > 1) ? $clog2(NITER) : 1;

  state_e         state_q, state_d;
  logic [ITW-1:0] iter_q, iter_d;
  logic           is_hex;

  assign is_hex = (func_i != FUNC_SDEC) && (func_i != FUNC_UDEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    last_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          iter_d     = '0;
          state_d    = is_hex ? ST_SCAN : ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.step = 1'b1;
        iter_d     = iter_q + 1'b1;
        if (iter_q == ITW'(NITER - 1)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        state_d    = sts_i.neg ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        out_valid_o    = 1'b1;
        cmd_o.sign_sel = 1'b1;
        if (out_ready_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        last_o      = sts_i.idx_zero;
        if (out_ready_i) begin
          if (sts_i.idx_zero) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.dec = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[rtl/i2a_dp.sv]
`timescale 1ns / 1ps

module i2a_dp #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [1:0]            func_i,
  input  i2a_pkg::cmd_t         cmd_i,
  output i2a_pkg::sts_t         sts_o,
  output logic [7:0]            ascii_char_o
);
  import i2a_pkg::*;

  localparam int NITER = (DATA_WIDTH + 3) / 4;
  localparam int NBITS = NITER * 4;
  localparam int NDEC  = (DATA_WIDTH * 3) / 10 + 1;
  localparam int NDIG  = (NDEC > NITER) ? NDEC : NITER;
  localparam int DIGW  = NDIG * 4;
  localparam int IDXW  = (NDIG > 1) ? $clog2(NDIG) : 1;

  logic [NBITS-1:0]      bin_q, bin_d;
  logic [DIGW-1:0]       bcd_q, bcd_d;
  logic                  neg_q, neg_d;
  logic [IDXW-1:0]       idx_q, idx_d;
  logic [NBITS-1:0]      bin_v;
  logic [DIGW-1:0]       bcd_v;
  logic [IDXW-1:0]       top_idx;
  logic                  negate;
  logic [DATA_WIDTH-1:0] mag;
  logic [3:0]            dig;
  logic [7:0]            dig_char;

  assign negate = (func_i == FUNC_SDEC) && value_i[DATA_WIDTH-1];
  assign mag    = negate ? (~value_i + 1'b1) : value_i;

  // four shift-add-3 steps per cycle
  always_comb begin
    bcd_v = bcd_q;
    bin_v = bin_q;
    for (int s = 0; s < 4; s++) begin
      for (int j = 0; j < NDIG; j++) begin
        if (bcd_v[j*4 +: 4] >= 4'd5) begin
          bcd_v[j*4 +: 4] = bcd_v[j*4 +: 4] + 4'd3;
        end
      end
      {bcd_v, bin_v} = {bcd_v[DIGW-2:0], bin_v, 1'b0};
    end
  end

  // highest nonzero digit, zero if none
  always_comb begin
    top_idx = '0;
    for (int j = 0; j < NDIG; j++) begin
      if (bcd_q[j*4 +: 4] != 4'd0) begin
        top_idx = IDXW'(j);
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    neg_d = neg_q;
    idx_d = idx_q;
    if (cmd_i.load) begin
      bin_d = NBITS'(mag);
      bcd_d = (func_i == FUNC_SDEC || func_i == FUNC_UDEC) ? '0 : DIGW'(mag);
      neg_d = negate;
    end
    if (cmd_i.step) begin
      bin_d = bin_v;
      bcd_d = bcd_v;
    end
    if (cmd_i.scan) begin
      idx_d = top_idx;
    end
    if (cmd_i.dec) begin
      idx_d = idx_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q <= 1'b0;
      idx_q <= '0;
    end else begin
      neg_q <= neg_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign dig      = bcd_q[{idx_q, 2'b00} +: 4];
  assign dig_char = ({4'b0, dig} < DEC_BASE) ? (CH_ZERO + {4'b0, dig})
                                             : (CH_ALPHA + {4'b0, dig} - DEC_BASE);

  assign ascii_char_o   = cmd_i.sign_sel ? CH_MINUS : dig_char;
  assign sts_o.neg      = neg_q;
  assign sts_o.idx_zero = (idx_q == '0);

endmodule

[rtl/integer_to_ascii_digits_unit.sv]
// path from accept to first word: hex through the scan state, decimal through the conversion states and the scan state
// one operand at a time: the next is taken only after the last word of the current one
// the decimal path runs the binary-to-bcd loop, four bits per cycle
// one word per cycle once emission starts, output held while out_ready_i is low
// reset: asynchronous active-low rst_ni, returns the controller to idle, nothing pending
`timescale 1ns / 1ps
`include "integer_to_ascii_digits_unit_macros.svh"

module integer_to_ascii_digits_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input word: operand and mode
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [1:0]            func_i,
  // output word: one character each
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            ascii_char_o,
  output logic                  last_o
);
  import i2a_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller: accept, bcd loop count, leading-digit scan, sign and digit emission
  i2a_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .last_o      (last_o)
  );

  // datapath: magnitude, shift-add-3 digit register, digit index and char mapping
  i2a_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .func_i       (func_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .ascii_char_o (ascii_char_o)
  );

  // a new operand is never taken while characters are still going out
  `I2A_ASSERT_SAME(a_no_overlap, out_valid_o, !in_ready_o, "input taken during emission")

  // the word after an accepted operand is never ready at once
  `I2A_ASSERT_NEXT(a_no_early_word, in_valid_i && in_ready_o, !out_valid_o, "word too early")

  // after the final word the block goes back to idle
  `I2A_ASSERT_NEXT(a_idle_after_last, out_valid_o && out_ready_i && last_o,
                   !out_valid_o && in_ready_o, "no return to idle after last word")

  // a minus sign is never the final character
  `I2A_ASSERT_SAME(a_sign_not_last, out_valid_o && ascii_char_o == CH_MINUS, !last_o,
                   "minus sign marked last")

endmodule

[dv/tb_integer_to_ascii_digits_unit.sv]
`timescale 1ns / 1ps

module tb_integer_to_ascii_digits_unit;
  import i2a_pkg::*;

  // mode 3 is not named in the package; the block decodes it as hex
  localparam logic [1:0] FUNC_ALT = 2'd3;

  localparam int RANDOM_WORDS = 460;
  localparam int CALM_TAIL    = 60;   // last random words run with no idling
  localparam int DRAIN_CYCLES = 30;   // settle time after the last character
  localparam int CYCLE_LIMIT  = 600000;

  // expected character stream, built per accepted operand
  class char_scoreboard;
    logic [7:0] char_q[$];
    bit         last_q[$];
    int         errors;
    int         checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    function int pending();
      return char_q.size();
    endfunction

    // render one operand as ascii, most significant digit first
    function void note_word(input logic [31:0] v, input logic [1:0] f);
      logic [31:0] mag;
      logic [31:0] radix;
      logic [3:0]  d;
      logic [7:0]  digs[$];
      bit          neg;
      mag = v;
      neg = 1'b0;
      radix = (f == FUNC_SDEC || f == FUNC_UDEC) ? 32'd10 : 32'd16;
      if (f == FUNC_SDEC && v[31]) begin
        // wraps to the full magnitude for the most negative value too
        neg = 1'b1;
        mag = 32'd0 - v;
      end
      do begin
        d = 4'(mag % radix);
        digs.push_front(d < 4'd10 ? 8'(CH_ZERO + d) : 8'(CH_ALPHA + d - 4'd10));
        mag = mag / radix;
      end while (mag != 32'd0);
      if (neg) begin
        char_q.push_back(CH_MINUS);
        last_q.push_back(1'b0);
      end
      foreach (digs[i]) begin
        char_q.push_back(digs[i]);
        last_q.push_back(i == digs.size() - 1);
      end
    endfunction

    function void check_word(input logic [7:0] ch, input logic lst);
      logic [7:0] exp_ch;
      bit         exp_last;
      checked++;
      if (char_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, char %h last %b", $time, ch, lst);
        return;
      end
      exp_ch   = char_q.pop_front();
      exp_last = last_q.pop_front();
      if (ch !== exp_ch) begin
        errors++;
        $display("%0t: char mismatch, expected %h actual %h", $time, exp_ch, ch);
      end
      if (lst !== exp_last) begin
        errors++;
        $display("%0t: last mismatch, expected %b actual %b", $time, exp_last, lst);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] value_i;
  logic [1:0]  func_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  ascii_char_o;
  logic        last_o;

  char_scoreboard sb;
  int  cycles;
  int  mode_count[4];
  bit  idle_en;       // random idling allowed on both sides
  int  stall_left;

  integer_to_ascii_digits_unit #(
    .DATA_WIDTH(32)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ascii_char_o(ascii_char_o),
    .last_o      (last_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // monitor: both handshakes sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_word(value_i, func_i);
      mode_count[func_i]++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word(ascii_char_o, last_o);
    end
  end

  // receiver: ready drops in random bursts while idling is on
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 17);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // present one operand, optionally after a gap, and hold it until accepted
  task automatic send_word(input logic [31:0] v, input logic [1:0] f, input int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    func_i     <= f;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending and wait for every expected character
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] v;
    logic [31:0] p;
    logic [1:0]  f;
    int          gap;

    sb          = new();
    cycles      = 0;
    idle_en     = 1'b0;
    stall_left  = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    func_i      = FUNC_SDEC;
    out_ready_i = 1'b0;
    foreach (mode_count[i]) mode_count[i] = 0;

    // reset held from the start, released at a falling edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero and the all-ones / sign-bit extremes in every mode
    for (int m = 0; m < 4; m++) begin
      send_word(32'h0000_0000, 2'(m), 0);
      send_word(32'hffff_ffff, 2'(m), 0);
      send_word(32'h8000_0000, 2'(m), 0);
    end
    // decimal digit-count edges and the largest positive signed value
    send_word(32'h7fff_ffff, FUNC_SDEC, 0);
    send_word(32'd1,         FUNC_SDEC, 0);
    send_word(32'hffff_fff6, FUNC_SDEC, 0);   // minus ten
    send_word(32'd9,         FUNC_UDEC, 0);
    send_word(32'd10,        FUNC_UDEC, 0);
    send_word(32'd1000000000, FUNC_UDEC, 0);
    // hex letters and digit-count edges
    send_word(32'h0000_000f, FUNC_HEX, 0);
    send_word(32'h0000_0010, FUNC_HEX, 0);
    send_word(32'hdead_beef, FUNC_HEX, 0);
    send_word(32'habcd_ef01, FUNC_ALT, 0);

    // hold the sender until the directed characters are all out
    drain();

    idle_en = 1'b1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // reroll idling every 32 words so calm stretches appear too
      if (n >= RANDOM_WORDS - CALM_TAIL) begin
        idle_en = 1'b0;
      end else if (n % 32 == 0) begin
        idle_en = ($urandom_range(0, 3) != 0);
      end
      if (n == RANDOM_WORDS / 2) begin
        drain();
      end

      case ($urandom_range(0, 5))
        0: v = $urandom();
        1: v = $urandom_range(0, 20);
        2: v = 32'h1 << $urandom_range(0, 31);
        3: v = ~(32'h1 << $urandom_range(0, 31));
        4: begin
          // around a power of ten
          p = 32'd1;
          repeat ($urandom_range(0, 9)) p = p * 32'd10;
          v = p + $urandom_range(0, 2) - 32'd1;
        end
        default: v = 32'd0 - $urandom_range(1, 100);
      endcase
      f = ($urandom_range(0, 7) == 0) ? FUNC_ALT : 2'($urandom_range(0, 2));
      gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      send_word(v, f, gap);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d signed, %0d unsigned, %0d hex and %0d mode-3 operands",
             mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    $display("checked %0d characters, %0d errors", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
